FILE: rtl/core/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared constants and helpers for the buddy block allocator
// Tree geometry, free-map word layout, status codes and small bit functions.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Tree geometry
    localparam int TREE_LEVELS     = 10;
    localparam int LEAF_BYTES_LOG2 = 4;
    localparam int POOL_LOG2       = TREE_LEVELS + LEAF_BYTES_LOG2;
    localparam int LEAF_COUNT      = 2 ** TREE_LEVELS;

    // Free map is packed into 32-bit words, each level starting on a new word
    localparam int WORD_LOG2 = 5;
    localparam int WORD_BITS = 2 ** WORD_LOG2;
    localparam int MAP_WORDS = (TREE_LEVELS < WORD_LOG2) ? TREE_LEVELS + 1
                             : 2 ** (TREE_LEVELS - WORD_LOG2 + 1) + 4;
    localparam int MAP_AW    = $clog2(MAP_WORDS);

    // Internal widths
    localparam int LVL_W  = $clog2(TREE_LEVELS + 1);
    localparam int IDX_W  = (TREE_LEVELS > WORD_LOG2) ? TREE_LEVELS : WORD_LOG2;
    localparam int CNT_W  = TREE_LEVELS + 1;
    localparam int LEN_W  = 6;

    // Port widths
    localparam int SIZE_W    = 32;
    localparam int OFF_IN_W  = 32;
    localparam int OFF_W     = 14;
    localparam int OUT_LVL_W = 4;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Word address of node (lvl, idx) in the free map
    function automatic logic [MAP_AW-1:0] map_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
        logic [MAP_AW:0]  base;
        logic [IDX_W-1:0] word;
        word = idx >> WORD_LOG2;
        if (int'(lvl) <= WORD_LOG2) begin
            base = (MAP_AW+1)'(lvl);
        end else begin
            base = (MAP_AW+1)'((1 << (int'(lvl) - WORD_LOG2)) + 4);
        end
        return MAP_AW'(base + (MAP_AW+1)'(word));
    endfunction

    // Number of significant bits of a value
    function automatic logic [LEN_W-1:0] bit_len(input logic [SIZE_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) n = LEN_W'(i + 1);
        end
        return n;
    endfunction

    // Position of the lowest set bit of a word
    function automatic logic [WORD_LOG2-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG2-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) p = WORD_LOG2'(i);
        end
        return p;
    endfunction

    function automatic logic [WORD_BITS-1:0] bit_mask(input logic [WORD_LOG2-1:0] pos);
        return WORD_BITS'(1) << pos;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/buddy_block_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_core: binary buddy allocator over a leaf pool
// Allocates lowest-index free blocks by splitting, frees by buddy merging.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                   | transfer
//  s_      | in        | operation, size_bytes, block_offset     | s_valid & s_ready
//  m_      | out       | status, granted_offset, block_level     | m_valid & m_ready
//
//  Allocate scans free-map words at the chosen level (up to 32 words), then
//  splits down to the wanted level; free merges with free buddies as it climbs,
//  and a taken buddy below the root stops the climb; a reject goes to the response.
//  Each free-map update reads the word and then writes it back through the RAM.
//  After reset a clearing pass over all MAP_WORDS (68) words runs before s_ready.
//  A result held by m_ready stalls the next transfer only at its response.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [31:0] s_size_bytes,
    input  wire logic [31:0] s_block_offset,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [13:0]      m_granted_offset,
    output logic [3:0]       m_block_level
);

    typedef enum logic [13:0] {
        ST_CLEAR       = 14'b00000000000001,
        ST_IDLE        = 14'b00000000000010,
        ST_DECODE      = 14'b00000000000100,
        ST_SCAN_RD     = 14'b00000000001000,
        ST_SCAN_CHK    = 14'b00000000010000,
        ST_SPLIT_RD    = 14'b00000000100000,
        ST_SPLIT_WR    = 14'b00000001000000,
        ST_LEAF_WR     = 14'b00000010000000,
        ST_LEAF_WAIT   = 14'b00000100000000,
        ST_BUDDY_RD    = 14'b00001000000000,
        ST_BUDDY_CHK   = 14'b00010000000000,
        ST_SET_RD      = 14'b00100000000000,
        ST_SET_WR      = 14'b01000000000000,
        ST_RESP        = 14'b10000000000000
    } state_t;

    localparam int L  = bba_pkg::TREE_LEVELS;
    localparam int LB = bba_pkg::LEAF_BYTES_LOG2;

    state_t state_reg, state_next;
    logic                                op_reg, op_next;
    logic [bba_pkg::SIZE_W-1:0]          size_reg, size_next;
    logic [bba_pkg::OFF_IN_W-1:0]        offset_reg, offset_next;
    logic [bba_pkg::LVL_W-1:0]           want_reg, want_next;
    logic [bba_pkg::LVL_W-1:0]           lvl_reg, lvl_next;
    logic [bba_pkg::LVL_W-1:0]           rec_reg, rec_next;
    logic [bba_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic [bba_pkg::IDX_W-1:0]           scan_w_reg, scan_w_next;
    logic [bba_pkg::MAP_AW-1:0]          addr_reg, addr_next;
    logic [bba_pkg::MAP_AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [bba_pkg::CNT_W-1:0]           cnt_reg [0:L];
    logic [1:0]                          res_status_reg, res_status_next;
    logic [bba_pkg::OFF_W-1:0]           res_off_reg, res_off_next;
    logic [bba_pkg::OUT_LVL_W-1:0]       res_lvl_reg, res_lvl_next;
    logic                                m_valid_reg, m_valid_next;
    logic [1:0]                          m_status_reg, m_status_next;
    logic [bba_pkg::OFF_W-1:0]           m_off_reg, m_off_next;
    logic [bba_pkg::OUT_LVL_W-1:0]       m_lvl_reg, m_lvl_next;

    // Free-map RAM port
    logic                           map_we;
    logic [bba_pkg::MAP_AW-1:0]     map_waddr, map_raddr;
    logic [bba_pkg::WORD_BITS-1:0]  map_wdata, map_rdata;
    logic [bba_pkg::WORD_BITS-1:0]  wr_set, wr_clr;
    logic                           clear_mode;

    // Leaf level RAM port
    logic                           leaf_we;
    logic [L-1:0]                   leaf_waddr, leaf_raddr;
    logic [bba_pkg::LVL_W-1:0]      leaf_wdata, leaf_rdata;

    // Level free counters update
    logic                           cnt_we;
    logic [bba_pkg::LVL_W-1:0]      cnt_sel;
    logic                           cnt_inc, cnt_dec;

    // Allocate decode
    logic [bba_pkg::SIZE_W-1:0]     units;
    logic [bba_pkg::LEN_W-1:0]      klen;
    logic                           too_big;
    logic [bba_pkg::LVL_W-1:0]      want_w;
    logic                           found;
    logic [bba_pkg::LVL_W-1:0]      pick_lvl;

    // Free decode
    logic                           out_of_pool;
    logic [bba_pkg::LVL_W-1:0]      rec_sat;
    logic [bba_pkg::IDX_W-1:0]      idx_f;

    // Scratch
    logic [bba_pkg::WORD_LOG2-1:0]  hit_pos;
    logic [bba_pkg::IDX_W-1:0]      child_idx, buddy_idx;
    logic [L-1:0]                   leaf_idx;

    bba_ram #(
        .DATA_W (bba_pkg::WORD_BITS),
        .DEPTH  (bba_pkg::MAP_WORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    bba_ram #(
        .DATA_W (bba_pkg::LVL_W),
        .DEPTH  (bba_pkg::LEAF_COUNT)
    ) u_leaf_ram (
        .aclk  (aclk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    // Round size up to a power of two of leaves and pick the deepest level with space
    always_comb begin
        units    = (size_reg == '0) ? '0 : (size_reg - bba_pkg::SIZE_W'(1)) >> LB;
        klen     = bba_pkg::bit_len(units);
        too_big  = (klen > bba_pkg::LEN_W'(L));
        want_w   = bba_pkg::LVL_W'(L - int'(klen));
        found    = 1'b0;
        pick_lvl = '0;
        for (int l = 0; l <= L; l++) begin
            if (l <= int'(want_w) && cnt_reg[l] != '0) begin
                found    = 1'b1;
                pick_lvl = bba_pkg::LVL_W'(l);
            end
        end
    end

    // Range check, saturate recorded level and form the block index
    always_comb begin
        out_of_pool = ((offset_reg >> bba_pkg::POOL_LOG2) != '0);
        leaf_raddr  = offset_reg[LB +: L];
        rec_sat     = (int'(leaf_rdata) > L) ? bba_pkg::LVL_W'(L) : leaf_rdata;
        idx_f       = bba_pkg::IDX_W'(offset_reg >> (L - int'(rec_sat) + LB));
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        offset_next     = offset_reg;
        want_next       = want_reg;
        lvl_next        = lvl_reg;
        rec_next        = rec_reg;
        idx_next        = idx_reg;
        scan_w_next     = scan_w_reg;
        addr_next       = addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_lvl_next    = res_lvl_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_off_next      = m_off_reg;
        m_lvl_next      = m_lvl_reg;

        map_raddr  = addr_reg;
        map_we     = 1'b0;
        map_waddr  = addr_reg;
        wr_set     = '0;
        wr_clr     = '0;
        clear_mode = 1'b0;
        leaf_we    = 1'b0;
        leaf_waddr = '0;
        leaf_wdata = want_reg;
        cnt_we     = 1'b0;
        cnt_sel    = lvl_reg;
        s_ready    = 1'b0;

        hit_pos   = bba_pkg::first_set(map_rdata);
        child_idx = idx_reg << 1;
        buddy_idx = idx_reg ^ bba_pkg::IDX_W'(1);
        leaf_idx  = L'(idx_reg << (L - int'(want_reg)));

        unique case (state_reg)
            ST_CLEAR: begin
                // Sweep the free map: only the root is free
                clear_mode   = 1'b1;
                map_we       = 1'b1;
                map_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + bba_pkg::MAP_AW'(1);
                if (int'(clr_cnt_reg) == bba_pkg::MAP_WORDS - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next     = s_operation;
                    size_next   = s_size_bytes;
                    offset_next = s_block_offset;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_off_next = '0;
                res_lvl_next = '0;
                if (op_reg == bba_pkg::OP_ALLOC) begin
                    if (too_big || !found) begin
                        res_status_next = bba_pkg::STAT_NOSPACE;
                        state_next      = ST_RESP;
                    end else begin
                        want_next   = want_w;
                        lvl_next    = pick_lvl;
                        scan_w_next = '0;
                        state_next  = ST_SCAN_RD;
                    end
                end else if (out_of_pool) begin
                    res_status_next = bba_pkg::STAT_RANGE;
                    state_next      = ST_RESP;
                end else begin
                    state_next = ST_LEAF_WAIT;
                end
            end
            ST_SCAN_RD: begin
                map_raddr  = bba_pkg::map_addr(lvl_reg, scan_w_reg << bba_pkg::WORD_LOG2);
                addr_next  = map_raddr;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                // Take the lowest free node in this word, else advance a word
                if (map_rdata != '0) begin
                    map_we   = 1'b1;
                    wr_clr   = bba_pkg::bit_mask(hit_pos);
                    cnt_we   = 1'b1;
                    idx_next = (scan_w_reg << bba_pkg::WORD_LOG2)
                             | bba_pkg::IDX_W'(hit_pos);
                    state_next = (lvl_reg == want_reg) ? ST_LEAF_WR : ST_SPLIT_RD;
                end else begin
                    scan_w_next = scan_w_reg + bba_pkg::IDX_W'(1);
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_SPLIT_RD: begin
                map_raddr  = bba_pkg::map_addr(lvl_reg + bba_pkg::LVL_W'(1), child_idx);
                addr_next  = map_raddr;
                state_next = ST_SPLIT_WR;
            end
            ST_SPLIT_WR: begin
                // Free the right half, keep the left half taken and descend
                map_we   = 1'b1;
                wr_clr   = bba_pkg::bit_mask(child_idx[bba_pkg::WORD_LOG2-1:0]);
                wr_set   = bba_pkg::bit_mask(child_idx[bba_pkg::WORD_LOG2-1:0]
                                             | bba_pkg::WORD_LOG2'(1));
                cnt_we   = 1'b1;
                cnt_sel  = lvl_reg + bba_pkg::LVL_W'(1);
                idx_next = child_idx;
                lvl_next = lvl_reg + bba_pkg::LVL_W'(1);
                state_next = (lvl_reg + bba_pkg::LVL_W'(1) == want_reg) ? ST_LEAF_WR
                                                                      : ST_SPLIT_RD;
            end
            ST_LEAF_WR: begin
                leaf_we         = 1'b1;
                leaf_waddr      = leaf_idx;
                res_status_next = bba_pkg::STAT_OK;
                res_off_next    = bba_pkg::OFF_W'(32'(leaf_idx) << LB);
                res_lvl_next    = bba_pkg::OUT_LVL_W'(want_reg);
                state_next      = ST_RESP;
            end
            ST_LEAF_WAIT: begin
                rec_next   = rec_sat;
                lvl_next   = rec_sat;
                idx_next   = idx_f;
                state_next = (rec_sat != '0) ? ST_BUDDY_RD : ST_SET_RD;
            end
            ST_BUDDY_RD: begin
                map_raddr  = bba_pkg::map_addr(lvl_reg, buddy_idx);
                addr_next  = map_raddr;
                state_next = ST_BUDDY_CHK;
            end
            ST_BUDDY_CHK: begin
                // Merge with a free buddy and climb, else stop
                if (map_rdata[buddy_idx[bba_pkg::WORD_LOG2-1:0]]) begin
                    map_we   = 1'b1;
                    wr_clr   = bba_pkg::bit_mask(buddy_idx[bba_pkg::WORD_LOG2-1:0]);
                    cnt_we   = 1'b1;
                    idx_next = idx_reg >> 1;
                    lvl_next = lvl_reg - bba_pkg::LVL_W'(1);
                    state_next = (lvl_reg == bba_pkg::LVL_W'(1)) ? ST_SET_RD : ST_BUDDY_RD;
                end else begin
                    state_next = ST_SET_RD;
                end
            end
            ST_SET_RD: begin
                map_raddr  = bba_pkg::map_addr(lvl_reg, idx_reg);
                addr_next  = map_raddr;
                state_next = ST_SET_WR;
            end
            ST_SET_WR: begin
                map_we          = 1'b1;
                wr_set          = bba_pkg::bit_mask(idx_reg[bba_pkg::WORD_LOG2-1:0]);
                cnt_we          = 1'b1;
                res_status_next = bba_pkg::STAT_OK;
                res_off_next    = '0;
                res_lvl_next    = bba_pkg::OUT_LVL_W'(rec_reg);
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_off_next    = res_off_reg;
                    m_lvl_next    = res_lvl_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (clear_mode) begin
            map_wdata = (clr_cnt_reg == '0) ? bba_pkg::WORD_BITS'(1) : '0;
        end else begin
            map_wdata = (map_rdata & ~wr_clr) | wr_set;
        end
        cnt_inc = |(wr_set & ~map_rdata);
        cnt_dec = |(wr_clr & map_rdata);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int l = 0; l <= L; l++) begin
                cnt_reg[l] <= (l == 0) ? bba_pkg::CNT_W'(1) : '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            for (int l = 0; l <= L; l++) begin
                if (cnt_we && int'(cnt_sel) == l) begin
                    cnt_reg[l] <= cnt_reg[l] + bba_pkg::CNT_W'(cnt_inc)
                                             - bba_pkg::CNT_W'(cnt_dec);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        offset_reg     <= offset_next;
        want_reg       <= want_next;
        lvl_reg        <= lvl_next;
        rec_reg        <= rec_next;
        idx_reg        <= idx_next;
        scan_w_reg     <= scan_w_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_lvl_reg    <= res_lvl_next;
        m_status_reg   <= m_status_next;
        m_off_reg      <= m_off_next;
        m_lvl_reg      <= m_lvl_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_offset = m_off_reg;
    assign m_block_level    = m_lvl_reg;

    // Checks
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !m_valid_reg)
        else $error("result valid during free-map clearing");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !map_we && !leaf_we)
        else $error("memory write while idle");

    a_root_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= bba_pkg::CNT_W'(1))
        else $error("root free count above one");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> int'(m_lvl_reg) <= L)
        else $error("result level beyond tree depth");

endmodule
`default_nettype wire

FILE: sim/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker: result predictor and scoreboard for the buddy block allocator
// Tracks the free tree and the per-leaf level store on every accepted request,
// queues the expected response and compares each response transfer with it.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_operation,
    input  wire logic [31:0] s_size_bytes,
    input  wire logic [31:0] s_block_offset,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [1:0]  m_status,
    input  wire logic [13:0] m_granted_offset,
    input  wire logic [3:0]  m_block_level,
    input  wire logic        end_check,
    output int               fail_count
);

    localparam int NODES = 2 * LEAF_COUNT - 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] offset;
        logic [3:0]  level;
    } grant_t;

    logic   node_free [NODES];
    logic [3:0] leaf_level [LEAF_COUNT];
    grant_t pending_grants [$];
    logic   end_seen;

    function automatic int node_id(int lvl, int idx);
        int n;
        n = (1 << lvl) - 1 + idx;
        return (n < NODES) ? n : 0;
    endfunction

    // Lowest-index free block at the deepest usable level, split down to size
    function automatic grant_t alloc_block(logic [31:0] size);
        grant_t g;
        int k, want, lvl, idx, leaf;
        logic hit;
        g = '0;
        g.status = STAT_NOSPACE;
        k = 0;
        while (k <= TREE_LEVELS && (64'd1 << (k + LEAF_BYTES_LOG2)) < 64'(size)) k++;
        if (k > TREE_LEVELS) return g;
        want = TREE_LEVELS - k;
        hit = 1'b0;
        idx = 0;
        lvl = want;
        for (int l = want; l >= 0 && !hit; l--) begin
            for (int j = 0; j < (1 << l) && !hit; j++) begin
                if (node_free[node_id(l, j)]) begin
                    hit = 1'b1;
                    lvl = l;
                    idx = j;
                end
            end
        end
        if (!hit) return g;
        node_free[node_id(lvl, idx)] = 1'b0;
        for (int l = lvl; l < want; l++) begin
            node_free[node_id(l + 1, 2 * idx + 1)] = 1'b1;
            idx = 2 * idx;
            node_free[node_id(l + 1, idx)] = 1'b0;
        end
        leaf = (idx << (TREE_LEVELS - want)) & (LEAF_COUNT - 1);
        leaf_level[leaf] = 4'(want);
        g.status = STAT_OK;
        g.offset = 14'(leaf << LEAF_BYTES_LOG2);
        g.level  = 4'(want);
        return g;
    endfunction

    // Release a block and merge with free buddies on the way up
    function automatic grant_t free_block(logic [31:0] off);
        grant_t g;
        int lvl, rec, idx;
        g = '0;
        if (64'(off) >= (64'd1 << POOL_LOG2)) begin
            g.status = STAT_RANGE;
            return g;
        end
        rec = leaf_level[(off >> LEAF_BYTES_LOG2) & (LEAF_COUNT - 1)];
        if (rec > TREE_LEVELS) rec = TREE_LEVELS;
        lvl = rec;
        idx = int'(off >> (TREE_LEVELS - lvl + LEAF_BYTES_LOG2));
        while (lvl > 0 && node_free[node_id(lvl, idx ^ 1)]) begin
            node_free[node_id(lvl, idx ^ 1)] = 1'b0;
            idx = idx >> 1;
            lvl--;
        end
        node_free[node_id(lvl, idx)] = 1'b1;
        g.status = STAT_OK;
        g.level  = 4'(rec);
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_t want_g;
        if (!aresetn) begin
            for (int n = 0; n < NODES; n++) node_free[n] = (n == 0);
            for (int n = 0; n < LEAF_COUNT; n++) leaf_level[n] = '0;
            pending_grants.delete();
            fail_count = 0;
            end_seen = 1'b0;
        end else begin
            // Compare a response transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_grants.size() == 0) begin
                    $display("%0t: unexpected response st=%0d off=%0d lvl=%0d", $time,
                             m_status, m_granted_offset, m_block_level);
                    fail_count++;
                end else begin
                    want_g = pending_grants.pop_front();
                    if (m_status !== want_g.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want_g.status, m_status);
                        fail_count++;
                    end
                    if (m_granted_offset !== want_g.offset) begin
                        $display("%0t: granted_offset expected %0d actual %0d", $time,
                                 want_g.offset, m_granted_offset);
                        fail_count++;
                    end
                    if (m_block_level !== want_g.level) begin
                        $display("%0t: block_level expected %0d actual %0d", $time,
                                 want_g.level, m_block_level);
                        fail_count++;
                    end
                end
            end
            // Predict the response of a request transfer
            if (s_valid && s_ready) begin
                if (s_operation == OP_ALLOC) pending_grants.push_back(alloc_block(s_size_bytes));
                else pending_grants.push_back(free_block(s_block_offset));
            end
            if (end_check && !end_seen) begin
                end_seen = 1'b1;
                if (pending_grants.size() != 0) begin
                    $display("%0t: %0d responses expected actual 0", $time,
                             pending_grants.size());
                    fail_count++;
                end
            end
        end
    end

endmodule

FILE: sim/tb_buddy_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator_core: stimulus and verdict for the buddy allocator
// Directed corner requests, then random allocate/free traffic over live blocks
// under several sender and receiver throttling phases; bba_checker scores it.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_core;
    import bba_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_ALLOC;
    logic [31:0] s_size_bytes = '0;
    logic [31:0] s_block_offset = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [13:0] m_granted_offset;
    logic [3:0]  m_block_level;
    logic        end_check = 1'b0;
    int          fail_count;

    int          gap_pct = 0;
    int          stall_pct = 0;
    logic        ops_in_flight [$];
    logic [13:0] live_blocks [$];
    logic        leaf_used [LEAF_COUNT];
    int          used_leaves [$];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    buddy_block_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_size_bytes(s_size_bytes), .s_block_offset(s_block_offset),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_granted_offset(m_granted_offset), .m_block_level(m_block_level)
    );

    bba_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_size_bytes(s_size_bytes), .s_block_offset(s_block_offset),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_granted_offset(m_granted_offset), .m_block_level(m_block_level),
        .end_check(end_check), .fail_count(fail_count)
    );

    // Record granted blocks so frees only touch leaves that hold a level
    always @(posedge aclk) begin
        logic op;
        if (aresetn) begin
            if (s_valid && s_ready) ops_in_flight.push_back(s_operation);
            if (m_valid && m_ready && ops_in_flight.size() != 0) begin
                op = ops_in_flight.pop_front();
                if (op == OP_ALLOC && m_status == STAT_OK) begin
                    live_blocks.push_back(m_granted_offset);
                    if (!leaf_used[m_granted_offset >> LEAF_BYTES_LOG2]) begin
                        leaf_used[m_granted_offset >> LEAF_BYTES_LOG2] = 1'b1;
                        used_leaves.push_back(m_granted_offset >> LEAF_BYTES_LOG2);
                    end
                end
            end
        end
    end

    // Throttle the response side
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Present one request and hold it until the transfer
    task automatic send_request(logic op, logic [31:0] size, logic [31:0] off);
        @(negedge aclk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_operation    = op;
        s_size_bytes   = size;
        s_block_offset = off;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic random_request();
        int r, pick;
        logic [31:0] val;
        r = $urandom_range(0, 99);
        if ((live_blocks.size() > 40 && r < 70) || (live_blocks.size() <= 40 && r < 35)) begin
            r = $urandom_range(0, 99);
            if (r < 80 && live_blocks.size() != 0) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                val = 32'(live_blocks[pick]);
                live_blocks.delete(pick);
            end else if (r < 92 && used_leaves.size() != 0) begin
                // stale or misaligned free inside a leaf that holds a level
                pick = used_leaves[$urandom_range(0, used_leaves.size() - 1)];
                val = 32'((pick << LEAF_BYTES_LOG2) + $urandom_range(0, 15));
            end else begin
                val = $urandom;
                if (val < 32'd16384) val[$urandom_range(14, 31)] = 1'b1;
            end
            send_request(OP_FREE, $urandom, val);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60)      val = $urandom_range(0, 64);
            else if (r < 85) val = $urandom_range(65, 2048);
            else if (r < 95) val = $urandom_range(2049, 16384);
            else             val = $urandom;
            send_request(OP_ALLOC, val, $urandom);
        end
    endtask

    initial begin
        for (int n = 0; n < LEAF_COUNT; n++) leaf_used[n] = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed corners: zero size, whole pool, too large, range, misaligned, double free
        send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_ALLOC, 32'd16384, 32'd0);
        send_request(OP_ALLOC, 32'd1, 32'd0);
        send_request(OP_ALLOC, 32'd16385, 32'd0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_FREE, 32'd0, 32'd16384);
        send_request(OP_FREE, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'd0, 32'd0);
        send_request(OP_ALLOC, 32'd17, 32'd0);
        send_request(OP_ALLOC, 32'd64, 32'd0);
        send_request(OP_ALLOC, 32'd16, 32'd0);
        send_request(OP_FREE, 32'd0, 32'd79);
        send_request(OP_FREE, 32'd0, 32'd79);
        send_request(OP_FREE, 32'd0, 32'd0);
        send_request(OP_FREE, 32'd0, 32'd0);
        send_request(OP_ALLOC, 32'h8000_0000, 32'd0);

        // Random traffic across throttling phases
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 48; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 48; end
                3: begin gap_pct = 16; stall_pct = 16; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            repeat (290) random_request();
        end

        @(negedge aclk);
        s_valid = 1'b0;
        stall_pct = 0;
        while (ops_in_flight.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        end_check = 1'b1;
        repeat (2) @(negedge aclk);
        if (fail_count == 0) begin
            $display("PASS buddy_block_allocator_core");
        end else begin
            $display("FAIL buddy_block_allocator_core");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL buddy_block_allocator_core");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/buddy_block_allocator_core.sv
sim/bba_checker.sv
sim/tb_buddy_block_allocator_core.sv
